// ===== hdl/evaluation_stack_alu_defines.svh =====
// Assertion macros shared by the evaluation stack RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef EVALUATION_STACK_ALU_DEFINES_SVH
`define EVALUATION_STACK_ALU_DEFINES_SVH

// Same-cycle implication.
`define ESA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/esa_pkg.sv =====
// Shared types, codes and constants of the evaluation stack.
// No dependencies; used by the interfaces, esa_alu, the top module and the testbench.
package esa_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int WORD_BITS_DEF   = 32;

  localparam int FUNC_W   = 4;
  localparam int OPND_W   = 32;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 8;
  localparam int COUNT_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 4'd0,
    FN_POP   = 4'd1,
    FN_PEEK  = 4'd2,
    FN_ADD   = 4'd3,
    FN_SUB   = 4'd4,
    FN_MUL   = 4'd5,
    FN_DIV   = 4'd6,
    FN_AND   = 4'd7,
    FN_OR    = 4'd8,
    FN_ALLOC = 4'd9
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FEW   = 3'd3,
    ST_DIVZ  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_AND,
    ALU_OR
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  function automatic alu_op_e func_to_alu(input logic [FUNC_W-1:0] f);
    alu_op_e op;
    op = ALU_ADD;
    case (f)
      FN_SUB:  op = ALU_SUB;
      FN_MUL:  op = ALU_MUL;
      FN_DIV:  op = ALU_DIV;
      FN_AND:  op = ALU_AND;
      FN_OR:   op = ALU_OR;
      default: op = ALU_ADD;
    endcase
    return op;
  endfunction

endpackage

// ===== hdl/esa_cfg_if.sv =====
// Configuration write channel: capacity limit register data.
// Depends on esa_pkg.
interface esa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [esa_pkg::CAP_W-1:0]    capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

// ===== hdl/esa_in_if.sv =====
// Command channel: opcode and operand word.
// Depends on esa_pkg.
interface esa_in_if;
  logic                              valid;
  logic                              ready;
  logic [esa_pkg::FUNC_W-1:0]        func;
  logic signed [esa_pkg::OPND_W-1:0] operand_value;

  modport source (output valid, func, operand_value, input ready);
  modport sink   (input valid, func, operand_value, output ready);
endinterface

// ===== hdl/esa_out_if.sv =====
// Result channel: result word, status and stack occupancy.
// Depends on esa_pkg.
interface esa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [esa_pkg::OPND_W-1:0] result_value;
  logic [esa_pkg::STATUS_W-1:0]      status_code;
  logic                              empty_flag;
  logic                              full_flag;
  logic [esa_pkg::COUNT_W-1:0]       entry_count;

  modport source (output valid, result_value, status_code, empty_flag, full_flag,
                  entry_count, input ready);
  modport sink   (input valid, result_value, status_code, empty_flag, full_flag,
                  entry_count, output ready);
endinterface

// ===== hdl/evaluation_stack_alu.sv =====
// Evaluation stack with a shared iterative ALU on its top two entries.
// Depends on esa_pkg, the channel interfaces, esa_mem and esa_alu.
//
// Usage:
//   in_i   : command transfers (func, operand_value). One command is taken
//            at a time; ready stays low until the previous command has
//            produced its result and that result sits in the output register.
//   out_o  : exactly one result transfer per command (value, status, flags,
//            entry count). The output register holds while the receiver
//            stalls; the next command is still taken meanwhile, and it waits
//            for the register to free before its result is posted.
//   cfg_i  : capacity limit writes, always ready. Write only while idle.
// Path from accept to result valid:
//   push, allocate, unknown opcode, other error cases : decided at dispatch
//   pop, peek                                         : reads the top word
//   divide by zero                                    : ALU not started
//   add, sub, and, or                                 : ALU state A_ONE
//   multiply                                          : ALU shift-add loop
//   divide                                            : ALU restoring loop
//   Multiply and divide run one bit per cycle on the single adder in esa_alu.
// Commands are taken one at a time; divide is the slowest.
// Reset: a clearing pass writes zero to every cell, with in_i ready low;
//   the capacity limit returns to 128.
`include "evaluation_stack_alu_defines.svh"

module evaluation_stack_alu #(
  parameter int STACK_DEPTH = esa_pkg::STACK_DEPTH_DEF,
  parameter int WORD_BITS   = esa_pkg::WORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  esa_cfg_if.sink    cfg_i,
  esa_in_if.sink     in_i,
  esa_out_if.source  out_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int KW = (CW > esa_pkg::CAP_W) ? CW : esa_pkg::CAP_W;
  localparam int MW = esa_pkg::OPND_W - 1;   // magnitude bits of the operand
  localparam logic [CW-1:0]        DEPTH_C  = CW'(STACK_DEPTH);
  localparam logic [AW-1:0]        CLR_LAST = AW'(STACK_DEPTH - 1);
  localparam logic [WORD_BITS-1:0] WSIGN    = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    S_CLEAR,   // zero the store after reset
    S_IDLE,    // take a command
    S_DISP,    // decide; push and allocate finish here
    S_RD1,     // top word arrives
    S_RD2,     // second word arrives, launch ALU unless divisor is zero
    S_EXEC,    // wait for ALU, write back
    S_DONE     // post result
  } state_e;

  state_e                             state_q;
  logic [AW-1:0]                      clr_q;
  logic [CW-1:0]                      fill_q;
  logic [esa_pkg::CAP_W-1:0]          cap_q;
  logic [esa_pkg::FUNC_W-1:0]         func_q;
  logic signed [esa_pkg::OPND_W-1:0]  opnd_q;
  logic [WORD_BITS-1:0]               b_q;
  logic [WORD_BITS-1:0]               res_q;
  esa_pkg::status_e                   st_q;

  logic                               out_valid_q;
  logic signed [esa_pkg::OPND_W-1:0]  out_res_q;
  logic [esa_pkg::STATUS_W-1:0]       out_st_q;
  logic                               out_empty_q;
  logic                               out_full_q;
  logic [esa_pkg::COUNT_W-1:0]        out_cnt_q;

  logic [KW-1:0]                      cap_wide;
  logic [CW-1:0]                      cap_eff;
  logic [WORD_BITS-1:0]               word;
  logic                               push_ok;
  logic [CW-1:0]                      alloc_room;
  logic                               alloc_ok;
  logic                               is_binary;
  logic                               div_zero;

  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic [WORD_BITS-1:0]               mem_wdata;
  logic [AW-1:0]                      mem_raddr;
  logic [WORD_BITS-1:0]               mem_rdata;

  esa_pkg::alu_req_t                  alu_req;
  logic                               alu_done;
  logic [WORD_BITS-1:0]               alu_res;

  // Clamp the capacity register to 1..STACK_DEPTH.
  always_comb begin
    cap_wide = KW'(cap_q);
    if (cap_wide == '0) begin
      cap_wide = KW'(1);
    end else if (cap_wide > KW'(STACK_DEPTH)) begin
      cap_wide = KW'(STACK_DEPTH);
    end
    cap_eff = CW'(cap_wide);
  end

  // Operand as a stack word: sign-extend or truncate to the word width.
  assign word       = WORD_BITS'(opnd_q);
  assign push_ok    = fill_q < cap_eff;
  assign alloc_room = cap_eff - fill_q;
  assign alloc_ok   = !opnd_q[esa_pkg::OPND_W-1] && (fill_q <= cap_eff) &&
                      (opnd_q[MW-1:0] <= MW'(alloc_room));
  assign is_binary  = (func_q >= esa_pkg::FN_ADD) && (func_q <= esa_pkg::FN_OR);
  assign div_zero   = (func_q == esa_pkg::FN_DIV) && (b_q == '0);

  // Store access: clearing, push write, ALU write-back; read top then second.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(fill_q);
    mem_wdata = word;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_DISP: begin
        mem_we = (func_q == esa_pkg::FN_PUSH) && push_ok;
      end
      S_EXEC: begin
        if (alu_done) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(fill_q - CW'(2));
          mem_wdata = alu_res;
        end
      end
      default: ;
    endcase
    mem_raddr = (state_q == S_RD1) ? AW'(fill_q - CW'(2)) : AW'(fill_q - CW'(1));
  end

  always_comb begin
    alu_req.start = (state_q == S_RD2) && !div_zero;
    alu_req.op    = esa_pkg::func_to_alu(func_q);
  end

  esa_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  esa_alu #(
    .WIDTH (WORD_BITS)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (mem_rdata),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fill_q      <= '0;
      cap_q       <= esa_pkg::CAP_RESET;
      func_q      <= '0;
      opnd_q      <= '0;
      b_q         <= '0;
      res_q       <= '0;
      st_q        <= esa_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_st_q    <= '0;
      out_empty_q <= 1'b0;
      out_full_q  <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity_limit;
      end
      // Drop valid once the receiver takes the result.
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLR_LAST) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            func_q  <= in_i.func;
            opnd_q  <= in_i.operand_value;
            state_q <= S_DISP;
          end
        end

        S_DISP: begin
          res_q   <= '0;
          st_q    <= esa_pkg::ST_OK;
          state_q <= S_DONE;
          if (func_q == esa_pkg::FN_PUSH) begin
            if (push_ok) begin
              fill_q <= fill_q + CW'(1);
              res_q  <= word;
            end else begin
              st_q <= esa_pkg::ST_FULL;
            end
          end else if ((func_q == esa_pkg::FN_POP) || (func_q == esa_pkg::FN_PEEK)) begin
            if (fill_q == '0) begin
              res_q <= WSIGN;
              st_q  <= esa_pkg::ST_EMPTY;
            end else begin
              state_q <= S_RD1;
            end
          end else if (is_binary) begin
            if (fill_q < CW'(2)) begin
              st_q <= esa_pkg::ST_FEW;
            end else begin
              state_q <= S_RD1;
            end
          end else if (func_q == esa_pkg::FN_ALLOC) begin
            // Cells come into use as they are; nothing is written.
            if (alloc_ok) begin
              fill_q <= fill_q + opnd_q[CW-1:0];
            end else begin
              st_q <= esa_pkg::ST_FULL;
            end
          end
        end

        S_RD1: begin
          if (is_binary) begin
            b_q     <= mem_rdata;
            state_q <= S_RD2;
          end else begin
            res_q   <= mem_rdata;
            state_q <= S_DONE;
            if (func_q == esa_pkg::FN_POP) begin
              fill_q <= fill_q - CW'(1);
            end
          end
        end

        S_RD2: begin
          if (div_zero) begin
            st_q    <= esa_pkg::ST_DIVZ;
            state_q <= S_DONE;
          end else begin
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (alu_done) begin
            fill_q  <= fill_q - CW'(1);
            res_q   <= alu_res;
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_res_q   <= esa_pkg::OPND_W'(res_q);
            out_st_q    <= st_q;
            out_empty_q <= (fill_q == '0);
            out_full_q  <= (fill_q >= cap_eff);
            out_cnt_q   <= esa_pkg::COUNT_W'(fill_q);
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.status_code  = out_st_q;
  assign out_o.empty_flag   = out_empty_q;
  assign out_o.full_flag    = out_full_q;
  assign out_o.entry_count  = out_cnt_q;

  `ESA_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= DEPTH_C, "fill count beyond built depth")
  `ESA_ASSERT_IMP(a_alu_done_exec, alu_done, state_q == S_EXEC, "ALU finished outside wait state")
  `ESA_ASSERT_NXT(a_full_push_holds, (state_q == S_DISP) && (func_q == esa_pkg::FN_PUSH) && !push_ok, fill_q == $past(fill_q), "refused push changed the fill count")
  `ESA_ASSERT_NXT(a_pop_drops_one, (state_q == S_RD1) && (func_q == esa_pkg::FN_POP), fill_q == $past(fill_q) - CW'(1), "pop did not remove exactly one entry")

endmodule

// ===== hdl/esa_mem.sv =====
// Stack word store: one write port, one read port with registered data.
// No dependencies.
module esa_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/esa_alu.sv =====
// Shared iterative ALU: one adder serves add, sub, shift-add multiply
// and restoring divide. Depends on esa_pkg.
module esa_alu #(
  parameter int WIDTH = esa_pkg::WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  esa_pkg::alu_req_t req_i,
  input  logic [WIDTH-1:0]  a_i,
  input  logic [WIDTH-1:0]  b_i,
  output logic              done_o,
  output logic [WIDTH-1:0]  result_o
);

  localparam int CNTW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    A_IDLE,
    A_ONE,
    A_NEGA,
    A_NEGB,
    A_ITER,
    A_NEGQ
  } alu_state_e;

  alu_state_e       state_q;
  esa_pkg::alu_op_e op_q;
  logic [WIDTH-1:0] acc_q;   // addend, product or remainder
  logic [WIDTH-1:0] dvd_q;   // multiplicand or dividend/quotient
  logic [WIDTH-1:0] opb_q;   // second operand, multiplier or divisor
  logic             neg_q;
  logic [CNTW-1:0]  cnt_q;
  logic             done_q;
  logic [WIDTH-1:0] res_q;

  logic [WIDTH-1:0] add_x;
  logic [WIDTH-1:0] add_y;
  logic             add_inv;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] shifted;

  assign shifted = {acc_q[WIDTH-2:0], dvd_q[WIDTH-1]};

  always_comb begin
    add_x   = acc_q;
    add_y   = opb_q;
    add_inv = 1'b0;
    unique case (state_q)
      A_ONE: begin
        add_inv = (op_q == esa_pkg::ALU_SUB);
      end
      A_NEGA, A_NEGQ: begin
        add_x   = '0;
        add_y   = dvd_q;
        add_inv = 1'b1;
      end
      A_NEGB: begin
        add_x   = '0;
        add_inv = 1'b1;
      end
      A_ITER: begin
        if (op_q == esa_pkg::ALU_MUL) begin
          add_y = dvd_q;
        end else begin
          add_x   = shifted;
          add_inv = 1'b1;
        end
      end
      default: ;
    endcase
    sum = {1'b0, add_x} + {1'b0, add_y ^ {WIDTH{add_inv}}} + (WIDTH+1)'(add_inv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= esa_pkg::ALU_ADD;
      acc_q   <= '0;
      dvd_q   <= '0;
      opb_q   <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            opb_q <= b_i;
            neg_q <= a_i[WIDTH-1] ^ b_i[WIDTH-1];
            cnt_q <= CNTW'(WIDTH - 1);
            unique case (req_i.op)
              esa_pkg::ALU_MUL: begin
                acc_q   <= '0;
                dvd_q   <= a_i;
                state_q <= A_ITER;
              end
              esa_pkg::ALU_DIV: begin
                acc_q   <= '0;
                dvd_q   <= a_i;
                state_q <= A_NEGA;
              end
              default: begin
                acc_q   <= a_i;
                state_q <= A_ONE;
              end
            endcase
          end
        end
        A_ONE: begin
          unique case (op_q)
            esa_pkg::ALU_AND: res_q <= WIDTH'((acc_q != '0) && (opb_q != '0));
            esa_pkg::ALU_OR:  res_q <= WIDTH'((acc_q != '0) || (opb_q != '0));
            default:          res_q <= sum[WIDTH-1:0];
          endcase
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        A_NEGA: begin
          // take magnitude of the dividend
          if (dvd_q[WIDTH-1]) begin
            dvd_q <= sum[WIDTH-1:0];
          end
          state_q <= A_NEGB;
        end
        A_NEGB: begin
          if (opb_q[WIDTH-1]) begin
            opb_q <= sum[WIDTH-1:0];
          end
          state_q <= A_ITER;
        end
        A_ITER: begin
          if (op_q == esa_pkg::ALU_MUL) begin
            // add shifted multiplicand when the multiplier bit is set
            if (opb_q[0]) begin
              acc_q <= sum[WIDTH-1:0];
            end
            dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
            opb_q <= {1'b0, opb_q[WIDTH-1:1]};
            if (cnt_q == '0) begin
              res_q   <= opb_q[0] ? sum[WIDTH-1:0] : acc_q;
              done_q  <= 1'b1;
              state_q <= A_IDLE;
            end
          end else begin
            // restoring step: keep the difference when no borrow
            acc_q <= sum[WIDTH] ? sum[WIDTH-1:0] : shifted;
            dvd_q <= {dvd_q[WIDTH-2:0], sum[WIDTH]};
            if (cnt_q == '0) begin
              state_q <= A_NEGQ;
            end
          end
          cnt_q <= cnt_q - 1'b1;
        end
        A_NEGQ: begin
          res_q   <= neg_q ? sum[WIDTH-1:0] : dvd_q;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== dv/tb_evaluation_stack_alu.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for evaluation_stack_alu: directed corner cases, then random.
// Depends on esa_pkg, esa_cfg_if, esa_in_if, esa_out_if and the evaluation_stack_alu RTL.

module tb_evaluation_stack_alu;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 60;   // covers the longest divide latency
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS  = 145;
  localparam int          FN_BITS      = esa_pkg::FUNC_W;

  localparam logic [31:0] INT_MIN_WORD = 32'h8000_0000;
  localparam logic [31:0] INT_MAX_WORD = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_ONE    = 32'hFFFF_FFFF;

  // Opcodes 10..15 carry no operation.
  localparam logic [esa_pkg::FUNC_W-1:0] FN_UNUSED_FIRST = 4'd10;
  localparam logic [esa_pkg::FUNC_W-1:0] FN_UNUSED_LAST  = 4'd15;

  // Capacity written at the start of each random phase; zero and values above the
  // built depth exercise the clamping.
  localparam logic [esa_pkg::CAP_W-1:0] PHASE_CAP [NUM_PHASES] = '{
    8'd128, 8'd1, 8'd255, 8'd9, 8'd0, 8'd2, 8'd64, 8'd127, 8'd3, 8'd16, 8'd200, 8'd128
  };

  // --------------------------------------------------------------------------
  // Stack predictor and result store.
  // --------------------------------------------------------------------------
  class stack_scoreboard;
    typedef struct {
      logic [31:0]                 value;
      esa_pkg::status_e            status;
      logic                        empty;
      logic                        full;
      logic [esa_pkg::COUNT_W-1:0] count;
    } stack_result_t;

    logic [31:0]               cells [esa_pkg::STACK_DEPTH_DEF];
    int unsigned               depth_used;
    logic [esa_pkg::CAP_W-1:0] capacity_reg;
    stack_result_t             pending_results [$];
    int unsigned               fail_count;

    function new();
      foreach (cells[i]) cells[i] = '0;
      depth_used   = 0;
      capacity_reg = esa_pkg::CAP_RESET;
      fail_count   = 0;
    endfunction

    function void set_capacity(logic [esa_pkg::CAP_W-1:0] v);
      capacity_reg = v;
    endfunction

    // Zero counts as one entry; values above the built depth clamp to it.
    function int unsigned effective_capacity();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > esa_pkg::STACK_DEPTH_DEF) return esa_pkg::STACK_DEPTH_DEF;
      return capacity_reg;
    endfunction

    // Signed divide, truncating toward zero; INT_MIN / -1 wraps back to INT_MIN.
    function logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
      longint sa, sb, q;
      sa = $signed(a);
      sb = $signed(b);
      q  = sa / sb;
      return q[31:0];
    endfunction

    // Advance the stack by one accepted command and queue the result it must give.
    function void note_command(logic [esa_pkg::FUNC_W-1:0] f, logic [31:0] opnd);
      stack_result_t want;
      int unsigned   lim;
      logic [31:0]   lhs, rhs, r;
      bit            applied;
      lim         = effective_capacity();
      want.value  = '0;
      want.status = esa_pkg::ST_OK;
      r           = '0;
      case (f)
        esa_pkg::FN_PUSH: begin
          if (depth_used >= lim) begin
            want.status = esa_pkg::ST_FULL;
          end else begin
            cells[depth_used] = opnd;
            depth_used++;
            want.value = opnd;
          end
        end
        esa_pkg::FN_POP, esa_pkg::FN_PEEK: begin
          if (depth_used == 0) begin
            want.value  = INT_MIN_WORD;
            want.status = esa_pkg::ST_EMPTY;
          end else begin
            want.value = cells[depth_used-1];
            if (f == esa_pkg::FN_POP) depth_used--;
          end
        end
        esa_pkg::FN_ADD, esa_pkg::FN_SUB, esa_pkg::FN_MUL,
        esa_pkg::FN_DIV, esa_pkg::FN_AND, esa_pkg::FN_OR: begin
          if (depth_used < 2) begin
            want.status = esa_pkg::ST_FEW;
          end else begin
            rhs     = cells[depth_used-1];
            lhs     = cells[depth_used-2];
            applied = 1'b1;
            case (f)
              esa_pkg::FN_ADD: r = lhs + rhs;
              esa_pkg::FN_SUB: r = lhs - rhs;
              esa_pkg::FN_MUL: r = lhs * rhs;
              esa_pkg::FN_DIV: begin
                if (rhs == 0) begin
                  applied     = 1'b0;
                  want.status = esa_pkg::ST_DIVZ;
                end else begin
                  r = trunc_quotient(lhs, rhs);
                end
              end
              esa_pkg::FN_AND: r = (lhs != 0 && rhs != 0) ? 32'd1 : 32'd0;
              default:         r = (lhs != 0 || rhs != 0) ? 32'd1 : 32'd0;
            endcase
            if (applied) begin
              depth_used--;
              cells[depth_used-1] = r;
              want.value = r;
            end
          end
        end
        esa_pkg::FN_ALLOC: begin
          // Allocation leaves cell contents alone; refuse negative or oversized counts.
          if (opnd[31] || depth_used > lim || opnd > (lim - depth_used))
            want.status = esa_pkg::ST_FULL;
          else
            depth_used += opnd;
        end
        default: ;
      endcase
      want.empty = (depth_used == 0);
      want.full  = (depth_used >= lim);
      want.count = depth_used[esa_pkg::COUNT_W-1:0];
      pending_results.push_back(want);
    endfunction

    function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%08h, actual 0x%08h", field_name, want, got);
        fail_count++;
      end
    endfunction

    // Match one result transfer against the oldest outstanding expectation.
    function void check_result(logic [31:0] value, logic [esa_pkg::STATUS_W-1:0] status,
                               logic empty, logic full,
                               logic [esa_pkg::COUNT_W-1:0] count);
      stack_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding: value 0x%08h status %0d",
               value, status);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_value", want.value, value);
      compare_field("status_code", 32'(want.status), 32'(status));
      compare_field("empty_flag", 32'(want.empty), 32'(empty));
      compare_field("full_flag", 32'(want.full), 32'(full));
      compare_field("entry_count", 32'(want.count), 32'(count));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block.
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  esa_cfg_if cfg_bus ();
  esa_in_if  cmd_bus ();
  esa_out_if rsp_bus ();

  evaluation_stack_alu u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (cmd_bus),
    .out_o  (rsp_bus)
  );

  stack_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned commands_sent;
  int unsigned results_seen;
  int unsigned cycle_count;
  logic        long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: drop ready at random, or hold it low for a long stretch on request
  // so the block backs up and stalls its command input.
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD;
        long_hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: check results before noting commands, since a result seen at the
  // same edge always belongs to an earlier command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        sb.check_result(rsp_bus.result_value, rsp_bus.status_code, rsp_bus.empty_flag,
                        rsp_bus.full_flag, rsp_bus.entry_count);
        results_seen++;
      end
      if (cfg_bus.valid && cfg_bus.ready)
        sb.set_capacity(cfg_bus.capacity_limit);
      if (cmd_bus.valid && cmd_bus.ready)
        sb.note_command(cmd_bus.func, cmd_bus.operand_value);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Offer one command, idling first at random, and return at the edge it transfers.
  task automatic send_command(logic [esa_pkg::FUNC_W-1:0] f, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.func          <= f;
    cmd_bus.operand_value <= v;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    commands_sent++;
  endtask

  // Hold the command channel idle until every outstanding result has transferred.
  task automatic wait_for_results();
    cmd_bus.valid <= 1'b0;
    while (results_seen < commands_sent) @(posedge clk_i);
  endtask

  // Write the capacity register; only called with the block idle.
  task automatic write_capacity(logic [esa_pkg::CAP_W-1:0] v);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.capacity_limit <= v;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Operand words lean on the extremes and on small values, so divides by zero,
  // zero operands of the logical ops and wrapping all show up often.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'd1;
      2:       return MINUS_ONE;
      3:       return INT_MIN_WORD;
      4:       return INT_MAX_WORD;
      5, 6:    return $urandom_range(18) - 9;
      default: return $urandom;
    endcase
  endfunction

  // Allocation counts around the room left: fits, exact fits, just past, negative.
  function automatic logic [31:0] pick_alloc_count();
    int unsigned lim, room;
    lim  = sb.effective_capacity();
    room = (lim > sb.depth_used) ? lim - sb.depth_used : 0;
    case ($urandom_range(9))
      0:       return $urandom | INT_MIN_WORD;
      1:       return room + 1 + $urandom_range(3);
      2:       return $urandom;
      3:       return room;
      default: return $urandom_range((room < 6) ? room : 6);
    endcase
  endfunction

  task automatic run_random(int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 32)
        send_command(esa_pkg::FN_PUSH, pick_word());
      else if (pick < 44)
        send_command(esa_pkg::FN_POP, $urandom);
      else if (pick < 49)
        send_command(esa_pkg::FN_PEEK, $urandom);
      else if (pick < 83)
        send_command(FN_BITS'($urandom_range(esa_pkg::FN_OR, esa_pkg::FN_ADD)), $urandom);
      else if (pick < 95)
        send_command(esa_pkg::FN_ALLOC, pick_alloc_count());
      else
        send_command(FN_BITS'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST)), $urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [esa_pkg::CAP_W-1:0] cap;
    sb = new();
    send_idle_pct          = 0;
    recv_idle_pct          = 0;
    commands_sent          = 0;
    results_seen           = 0;
    cycle_count            = 0;
    long_hold_req          = 1'b0;
    cmd_bus.valid          = 1'b0;
    cmd_bus.func           = '0;
    cmd_bus.operand_value  = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.capacity_limit = '0;
    rst_ni                 = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-stack reads, too few operands, wrapping, division corners,
    // logical ops, refused and accepted allocations, an unknown opcode.
    send_command(esa_pkg::FN_POP, '0);
    send_command(esa_pkg::FN_PEEK, '0);
    send_command(esa_pkg::FN_ADD, '0);
    send_command(esa_pkg::FN_PUSH, INT_MIN_WORD);
    send_command(esa_pkg::FN_SUB, '0);
    send_command(esa_pkg::FN_PUSH, MINUS_ONE);
    send_command(esa_pkg::FN_DIV, '0);            // INT_MIN / -1 wraps to INT_MIN
    send_command(esa_pkg::FN_PUSH, '0);
    send_command(esa_pkg::FN_DIV, '0);            // divide by zero, stack kept
    send_command(esa_pkg::FN_OR, '0);
    send_command(esa_pkg::FN_PUSH, INT_MAX_WORD);
    send_command(esa_pkg::FN_ADD, '0);            // wraps past INT_MAX
    send_command(esa_pkg::FN_PUSH, INT_MAX_WORD);
    send_command(esa_pkg::FN_MUL, '0);
    send_command(esa_pkg::FN_PUSH, -32'sd7);
    send_command(esa_pkg::FN_PUSH, 32'd2);
    send_command(esa_pkg::FN_DIV, '0);            // truncates toward zero
    send_command(esa_pkg::FN_PUSH, '0);
    send_command(esa_pkg::FN_AND, '0);
    send_command(esa_pkg::FN_ALLOC, MINUS_ONE);   // negative count refused
    send_command(esa_pkg::FN_ALLOC, 32'd200);     // past capacity refused
    send_command(esa_pkg::FN_ALLOC, '0);
    send_command(esa_pkg::FN_ALLOC, 32'd3);       // cells keep old contents
    send_command(esa_pkg::FN_POP, '0);
    send_command(FN_UNUSED_LAST, MINUS_ONE);
    wait_for_results();

    // Back-pressure: hold the receiver off while commands keep coming, then let
    // the sender pause until everything has drained.
    write_capacity(esa_pkg::CAP_RESET);
    long_hold_req <= 1'b1;
    for (int i = 0; i < 12; i++) send_command(esa_pkg::FN_PUSH, $urandom);
    send_command(esa_pkg::FN_ALLOC, 32'd2);
    send_command(esa_pkg::FN_ALLOC, 32'd2);
    wait_for_results();

    // Lower capacity below the fill: entries stay, pushes and allocations refused.
    write_capacity(8'd4);
    send_command(esa_pkg::FN_PUSH, $urandom);
    send_command(esa_pkg::FN_ALLOC, '0);
    send_command(esa_pkg::FN_PEEK, '0);
    send_command(esa_pkg::FN_POP, '0);
    send_command(esa_pkg::FN_SUB, '0);
    wait_for_results();

    // Random phases: sender-light then receiver-light idling, then none at all.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < NUM_PHASES / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 66;
      end else if (ph < 2 * NUM_PHASES / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cap = PHASE_CAP[ph];
      write_capacity(cap);
      run_random(PHASE_ITEMS);
      wait_for_results();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/esa_pkg.sv
hdl/esa_cfg_if.sv
hdl/esa_in_if.sv
hdl/esa_out_if.sv
hdl/esa_mem.sv
hdl/esa_alu.sv
hdl/evaluation_stack_alu.sv
dv/tb_evaluation_stack_alu.sv
